>>> rtl/bbm_pkg.sv
// Shared types, request codes and defaults for the bad-block map allocator.
`timescale 1ns / 1ps

package bbm_pkg;

  localparam int BLOCKS_DEF          = 2048;
  localparam int PAGES_PER_BLOCK_DEF = 64;
  localparam int QUEUE_DEPTH         = 2;

  localparam int REQ_W  = 3;
  localparam int BLK_W  = 12;
  localparam int PAGE_W = 18;
  localparam int ADDR_W = 17;
  localparam int NUM_W  = 32;

  localparam logic [REQ_W-1:0] REQ_MARK_BAD     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_MARK_GOOD    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY_BLOCK  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_QUERY_PAGE   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR_MAP    = 3'd4;
  localparam logic [REQ_W-1:0] REQ_NEW_FILE     = 3'd5;
  localparam logic [REQ_W-1:0] REQ_PAGE_WRITTEN = 3'd6;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [BLK_W-1:0]  block_index;
    logic [PAGE_W-1:0] page_address;
  } req_t;

  typedef struct packed {
    logic              status;
    logic              is_bad;
    logic [ADDR_W-1:0] write_address;
    logic [ADDR_W-1:0] next_address;
    logic [ADDR_W-1:0] file_start;
    logic [NUM_W-1:0]  file_number;
    logic [NUM_W-1:0]  page_in_file;
  } res_t;

  typedef enum logic [2:0] {
    OP_MARK,
    OP_QUERY,
    OP_CLEAR,
    OP_NEW_FILE,
    OP_PAGE_WR,
    OP_BAD_CODE
  } op_e;

  // Classified item handed from the front end to the executor.
  typedef struct packed {
    op_e              op;
    logic             mark_bad;
    logic             out_of_range;
    logic [BLK_W-1:0] blk;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_QUERY,
    ST_SKIP
  } back_state_e;

endpackage

>>> rtl/nand_bad_block_map_allocator_top.sv
// Top level of the NAND bad-block map and ring write pointer allocator.
`timescale 1ns / 1ps

// Usage:
//   Request channel: drive req_i and raise start; the item is taken at a rising
//   edge where start is high and busy is low. Result channel: valid_o is high
//   for exactly one cycle with res_o; the receiver must take it then, there is
//   no back-pressure.
//   Structure: a front end registers each item (with the page-to-block
//   multiply) and classifies it, a two-entry queue decouples it from the
//   executor, which owns the one-bit-per-block map RAM and the file state.
//   Marks, out-of-range queries, bad codes and a refused page write are
//   answered from the queue head; in-range queries first read the map;
//   new file and page written read the map and skip the k bad blocks in
//   their way (one map read per block, at most BLOCKS); clear map sweeps
//   the map RAM one entry per cycle.
//   Throughput: one single-cycle item per clock in steady state; outside
//   the reset sweep busy rises only when front register and queue are both full.
//   Reset: after rst_ni releases, the executor sweeps all BLOCKS map entries
//   to good (2048 by default); busy stays high meanwhile.
//   Results come out in request order.
module nand_bad_block_map_allocator_top import bbm_pkg::*; #(
  parameter int BLOCKS          = BLOCKS_DEF,
  parameter int PAGES_PER_BLOCK = PAGES_PER_BLOCK_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic valid_o,
  output res_t res_o
);

  // Front end to queue.
  logic push;
  cmd_t push_cmd;
  logic q_full;

  // Queue to executor.
  logic pop;
  cmd_t head_cmd;
  logic q_empty;

  // Executor still clearing the map after reset.
  logic init;

  bbm_front #(
    .BLOCKS          (BLOCKS),
    .PAGES_PER_BLOCK (PAGES_PER_BLOCK)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .req_i   (req_i),
    .init_i  (init),
    .full_i  (q_full),
    .busy_o  (busy),
    .push_o  (push),
    .cmd_o   (push_cmd)
  );

  bbm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .pop_i   (pop),
    .data_o  (head_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  bbm_back #(
    .BLOCKS          (BLOCKS),
    .PAGES_PER_BLOCK (PAGES_PER_BLOCK)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .cmd_i   (head_cmd),
    .pop_o   (pop),
    .init_o  (init),
    .valid_o (valid_o),
    .res_o   (res_o)
  );

endmodule

>>> rtl/bbm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bbm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bbm_front.sv
// Front end: accepts requests, locates the block of a page and classifies the item.
`timescale 1ns / 1ps

module bbm_front import bbm_pkg::*; #(
  parameter int BLOCKS          = BLOCKS_DEF,
  parameter int PAGES_PER_BLOCK = PAGES_PER_BLOCK_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  input  logic init_i,
  input  logic full_i,
  output logic busy_o,
  output logic push_o,
  output cmd_t cmd_o
);

  // Page to block by reciprocal multiply; exact for every PAGE_W-bit page.
  localparam int LOG_PPB = $clog2(PAGES_PER_BLOCK);
  localparam int SHIFT   = PAGE_W + LOG_PPB;
  localparam int RECIP_W = PAGE_W + 1;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(PAGES_PER_BLOCK) - 64'd1) / 64'(PAGES_PER_BLOCK);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
  localparam int PROD_W = PAGE_W + RECIP_W;
  localparam int QUOT_W = PROD_W - SHIFT;

  logic              stage_valid_q, stage_valid_d;
  logic [REQ_W-1:0]  stage_type_q;
  logic [BLK_W-1:0]  stage_blk_q;
  logic [PROD_W-1:0] stage_prod_q;
  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] quot;
  logic              accept;
  logic              blk_oor;
  logic              page_oor;

  assign busy_o = init_i | (stage_valid_q & full_i);
  assign accept = start_i & ~busy_o;
  assign push_o = stage_valid_q & ~full_i;
  assign prod   = PROD_W'(req_i.page_address) * PROD_W'(RECIP);

  assign stage_valid_d = accept | (stage_valid_q & ~push_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_type_q <= req_i.req_type;
      stage_blk_q  <= req_i.block_index;
      stage_prod_q <= prod;
    end
  end

  assign quot     = stage_prod_q[PROD_W-1:SHIFT];
  assign blk_oor  = 32'(stage_blk_q) >= 32'(BLOCKS);
  assign page_oor = 32'(quot) >= 32'(BLOCKS);

  always_comb begin
    cmd_o.op           = OP_BAD_CODE;
    cmd_o.mark_bad     = 1'b0;
    cmd_o.out_of_range = 1'b0;
    cmd_o.blk          = stage_blk_q;
    case (stage_type_q)
      REQ_MARK_BAD, REQ_MARK_GOOD: begin
        cmd_o.op           = OP_MARK;
        cmd_o.mark_bad     = stage_type_q inside {REQ_MARK_BAD};
        cmd_o.out_of_range = blk_oor;
      end
      REQ_QUERY_BLOCK: begin
        cmd_o.op           = OP_QUERY;
        cmd_o.out_of_range = blk_oor;
      end
      REQ_QUERY_PAGE: begin
        cmd_o.op           = OP_QUERY;
        cmd_o.out_of_range = page_oor;
        cmd_o.blk          = BLK_W'(quot);
      end
      REQ_CLEAR_MAP:    cmd_o.op = OP_CLEAR;
      REQ_NEW_FILE:     cmd_o.op = OP_NEW_FILE;
      REQ_PAGE_WRITTEN: cmd_o.op = OP_PAGE_WR;
      default:          cmd_o.op = OP_BAD_CODE;
    endcase
  end

endmodule

>>> rtl/bbm_queue.sv
// Short FIFO of classified items between front end and executor.
`timescale 1ns / 1ps

module bbm_queue import bbm_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output cmd_t data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == CNT_W'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i)
    else $error("item pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("item popped from empty queue");
`endif

endmodule

>>> rtl/bbm_back.sv
// Executor: bad-block map, file state and the ring write pointer with bad-block skip.
`timescale 1ns / 1ps

module bbm_back import bbm_pkg::*; #(
  parameter int BLOCKS          = BLOCKS_DEF,
  parameter int PAGES_PER_BLOCK = PAGES_PER_BLOCK_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic empty_i,
  input  cmd_t cmd_i,
  output logic pop_o,
  output logic init_o,
  output logic valid_o,
  output res_t res_o
);

  localparam int AW = $clog2(BLOCKS);
  localparam int OW = (PAGES_PER_BLOCK > 1) ? $clog2(PAGES_PER_BLOCK) : 1;
  localparam int PW = $clog2(BLOCKS * PAGES_PER_BLOCK);
  localparam int LW = (PW > ADDR_W) ? PW : ADDR_W;
  localparam int TW = $clog2(BLOCKS + 1);

  back_state_e       state_q, state_d;
  logic              file_open_q, file_open_d;
  logic [NUM_W-1:0]  fnum_q, fnum_d;
  logic [NUM_W-1:0]  pcnt_q, pcnt_d;
  logic [ADDR_W-1:0] start_q, start_d;
  logic [AW-1:0]     wp_blk_q, wp_blk_d;
  logic [OW-1:0]     wp_off_q, wp_off_d;
  logic [PW-1:0]     wp_base_q, wp_base_d;
  logic [TW-1:0]     tries_q, tries_d;
  logic [AW-1:0]     sweep_q, sweep_d;
  logic              skip_new_q, skip_new_d;
  logic              res_valid_q, res_valid_d;
  logic              res_status_q, res_status_d;
  logic              res_bad_q, res_bad_d;
  logic [ADDR_W-1:0] res_written_q, res_written_d;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic              ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic              ram_rdata;

  logic [LW-1:0]     lin_ext;
  logic [ADDR_W-1:0] lin;
  logic              last_blk;
  logic [AW-1:0]     fb_blk;
  logic [PW-1:0]     fb_base;
  logic              last_page;
  logic [AW-1:0]     cmd_blk;

  bbm_ram #(
    .WIDTH (1),
    .DEPTH (BLOCKS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Pointer kept as block, page offset and block base page.
  assign lin_ext   = LW'(wp_base_q) + LW'(wp_off_q);
  assign lin       = lin_ext[ADDR_W-1:0];
  assign last_blk  = wp_blk_q == AW'(BLOCKS - 1);
  assign fb_blk    = last_blk ? '0 : wp_blk_q + 1'b1;
  assign fb_base   = last_blk ? '0 : wp_base_q + PW'(PAGES_PER_BLOCK);
  assign last_page = ({1'b0, wp_off_q} + 1'b1) == (OW + 1)'(PAGES_PER_BLOCK);
  assign cmd_blk   = cmd_i.blk[AW-1:0];

  always_comb begin
    state_d       = state_q;
    file_open_d   = file_open_q;
    fnum_d        = fnum_q;
    pcnt_d        = pcnt_q;
    start_d       = start_q;
    wp_blk_d      = wp_blk_q;
    wp_off_d      = wp_off_q;
    wp_base_d     = wp_base_q;
    tries_d       = tries_q;
    sweep_d       = sweep_q;
    skip_new_d    = skip_new_q;
    res_valid_d   = 1'b0;
    res_status_d  = res_status_q;
    res_bad_d     = res_bad_q;
    res_written_d = res_written_q;
    ram_we        = 1'b0;
    ram_waddr     = cmd_blk;
    ram_wdata     = 1'b0;
    ram_raddr     = cmd_blk;
    pop_o         = 1'b0;

    case (state_q)
      ST_INIT, ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        if (sweep_q == AW'(BLOCKS - 1)) begin
          sweep_d = '0;
          state_d = ST_IDLE;
          if (state_q == ST_CLEAR) begin
            res_valid_d = 1'b1;
          end
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o         = 1'b1;
          res_status_d  = 1'b0;
          res_bad_d     = 1'b0;
          res_written_d = '0;
          case (cmd_i.op)
            OP_MARK: begin
              res_valid_d = 1'b1;
              if (cmd_i.out_of_range) begin
                res_status_d = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_wdata = cmd_i.mark_bad;
              end
            end
            OP_QUERY: begin
              if (cmd_i.out_of_range) begin
                res_valid_d = 1'b1;
                res_bad_d   = 1'b1;
              end else begin
                state_d = ST_QUERY;
              end
            end
            OP_CLEAR: begin
              state_d = ST_CLEAR;
            end
            OP_NEW_FILE: begin
              fnum_d      = file_open_q ? fnum_q + 32'd1 : 32'd1;
              pcnt_d      = '0;
              file_open_d = 1'b1;
              tries_d     = '0;
              skip_new_d  = 1'b1;
              wp_off_d    = '0;
              if (file_open_q) begin
                wp_blk_d  = fb_blk;
                wp_base_d = fb_base;
                ram_raddr = fb_blk;
              end else begin
                wp_blk_d  = '0;
                wp_base_d = '0;
                ram_raddr = '0;
              end
              state_d = ST_SKIP;
            end
            OP_PAGE_WR: begin
              if (!file_open_q) begin
                res_valid_d  = 1'b1;
                res_status_d = 1'b1;
              end else begin
                res_written_d = lin;
                pcnt_d        = pcnt_q + 32'd1;
                tries_d       = '0;
                skip_new_d    = 1'b0;
                if (last_page) begin
                  wp_blk_d  = fb_blk;
                  wp_base_d = fb_base;
                  wp_off_d  = '0;
                  ram_raddr = fb_blk;
                end else begin
                  wp_off_d  = wp_off_q + 1'b1;
                  ram_raddr = wp_blk_q;
                end
                state_d = ST_SKIP;
              end
            end
            default: begin
              res_valid_d  = 1'b1;
              res_status_d = 1'b1;
            end
          endcase
        end
      end
      ST_QUERY: begin
        res_valid_d = 1'b1;
        res_bad_d   = ram_rdata;
        state_d     = ST_IDLE;
      end
      ST_SKIP: begin
        // Map bit of the pointer's block arrives here; hop one block per cycle.
        if (!ram_rdata || tries_q == TW'(BLOCKS)) begin
          res_valid_d  = 1'b1;
          res_status_d = ram_rdata;
          if (skip_new_q) begin
            start_d = lin;
          end
          state_d = ST_IDLE;
        end else begin
          tries_d   = tries_q + 1'b1;
          wp_blk_d  = fb_blk;
          wp_base_d = fb_base;
          wp_off_d  = '0;
          ram_raddr = fb_blk;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      file_open_q <= 1'b0;
      fnum_q      <= '0;
      pcnt_q      <= '0;
      start_q     <= '0;
      wp_blk_q    <= '0;
      wp_off_q    <= '0;
      wp_base_q   <= '0;
      tries_q     <= '0;
      sweep_q     <= '0;
      skip_new_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      file_open_q <= file_open_d;
      fnum_q      <= fnum_d;
      pcnt_q      <= pcnt_d;
      start_q     <= start_d;
      wp_blk_q    <= wp_blk_d;
      wp_off_q    <= wp_off_d;
      wp_base_q   <= wp_base_d;
      tries_q     <= tries_d;
      sweep_q     <= sweep_d;
      skip_new_q  <= skip_new_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q  <= res_status_d;
    res_bad_q     <= res_bad_d;
    res_written_q <= res_written_d;
  end

  assign init_o  = state_q == ST_INIT;
  assign valid_o = res_valid_q;

  always_comb begin
    res_o.status        = res_status_q;
    res_o.is_bad        = res_bad_q;
    res_o.write_address = res_written_q;
    res_o.next_address  = lin;
    res_o.file_start    = start_q;
    res_o.file_number   = fnum_q;
    res_o.page_in_file  = pcnt_q;
  end

`ifndef SYNTHESIS
  a_base_matches_blk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(wp_base_q) == 32'(wp_blk_q) * 32'(PAGES_PER_BLOCK))
    else $error("pointer base page out of step with block");
  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(wp_blk_q) < 32'(BLOCKS) && 32'(wp_off_q) < 32'(PAGES_PER_BLOCK))
    else $error("write pointer outside page space");
  a_no_result_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_INIT |-> !res_valid_q && !pop_o)
    else $error("item handled during map initialization");
`endif

endmodule

>>> verif/nand_bad_block_map_allocator_top_test.sv
// Self-checking bench for the bad-block map allocator: directed, exhaustion and random items.
`timescale 1ns / 1ps

module nand_bad_block_map_allocator_top_test import bbm_pkg::*; ();

  // Geometry of the default build; the shadow state below follows it.
  localparam int NBLK        = BLOCKS_DEF;
  localparam int PPB         = PAGES_PER_BLOCK_DEF;
  localparam int PAGE_SPACE  = NBLK * PPB;
  localparam int MAX_REPORTS = 10;

  // The one 3-bit request code that the block does not define.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  req_t req_r  = '0;
  logic busy;
  logic valid_o;
  res_t res_o;

  // Shadow of the allocator: bad bits, file state and ring write pointer.
  bit               shadow_map [NBLK];
  bit               file_is_open;
  logic [NUM_W-1:0] file_num;
  logic [NUM_W-1:0] file_page_cnt;
  int unsigned      file_first_page;
  int unsigned      write_ptr;

  // Replies owed by the block, oldest first.
  res_t        pending_replies [$];
  int unsigned reply_mismatches = 0;

  // Chance in percent that the sender holds start low before an item.
  int          idle_pct = 15;
  int unsigned req_count = 0;

  always #5 clk_i = ~clk_i;

  nand_bad_block_map_allocator_top uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .req_i   (req_r),
    .busy    (busy),
    .valid_o (valid_o),
    .res_o   (res_o)
  );

  // ---------------------------------------------------------------------------
  // Shadow allocator
  // ---------------------------------------------------------------------------

  // Treat any block past the end of the map as bad.
  function automatic bit block_bad(int unsigned b);
    if (b >= NBLK) return 1'b1;
    return shadow_map[b];
  endfunction

  // First page of the block after the one holding p, wrapping at the ring end.
  function automatic int unsigned next_block_start(int unsigned p);
    int unsigned n;
    n = (p / PPB + 1) * PPB;
    return (n >= PAGE_SPACE) ? 0 : n;
  endfunction

  // Walk p forward over bad blocks; give up after one full lap of advances.
  task automatic skip_bad_blocks(inout int unsigned p, output logic gave_up);
    int unsigned tries;
    tries   = 0;
    gave_up = 1'b0;
    while (block_bad(p / PPB) && !gave_up) begin
      if (tries >= NBLK) begin
        gave_up = 1'b1;
      end else begin
        tries++;
        p = next_block_start(p);
      end
    end
  endtask

  // Apply one accepted item to the shadow state and queue the reply it owes.
  task automatic allocator_reply(input req_t r);
    res_t        rep;
    int unsigned s;
    logic        fail;
    rep = '0;
    case (r.req_type)
      REQ_MARK_BAD, REQ_MARK_GOOD: begin
        if (r.block_index >= NBLK) rep.status = 1'b1;
        else shadow_map[r.block_index] = (r.req_type == REQ_MARK_BAD);
      end
      REQ_QUERY_BLOCK: rep.is_bad = block_bad(r.block_index);
      REQ_QUERY_PAGE:  rep.is_bad = block_bad(r.page_address / PPB);
      REQ_CLEAR_MAP: begin
        foreach (shadow_map[i]) shadow_map[i] = 1'b0;
      end
      REQ_NEW_FILE: begin
        // The first file searches from page 0, later ones from the next block.
        if (file_is_open) begin
          file_num = file_num + 1'b1;
          s        = next_block_start(write_ptr);
        end else begin
          file_num = 1;
          s        = 0;
        end
        skip_bad_blocks(s, fail);
        rep.status      = fail;
        file_first_page = s;
        write_ptr       = s;
        file_page_cnt   = '0;
        file_is_open    = 1'b1;
      end
      REQ_PAGE_WRITTEN: begin
        if (!file_is_open) begin
          rep.status = 1'b1;
        end else begin
          rep.write_address = ADDR_W'(write_ptr);
          file_page_cnt     = file_page_cnt + 1'b1;
          s = (write_ptr + 1 >= PAGE_SPACE) ? 0 : write_ptr + 1;
          skip_bad_blocks(s, fail);
          rep.status = fail;
          write_ptr  = s;
        end
      end
      default: rep.status = 1'b1;
    endcase
    rep.next_address = ADDR_W'(write_ptr);
    rep.file_start   = ADDR_W'(file_first_page);
    rep.file_number  = file_num;
    rep.page_in_file = file_page_cnt;
    pending_replies.push_back(rep);
  endtask

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  function automatic req_t mk_req(logic [REQ_W-1:0] t, int unsigned b, int unsigned p);
    req_t r;
    r.req_type     = t;
    r.block_index  = BLK_W'(b);
    r.page_address = PAGE_W'(p);
    return r;
  endfunction

  function automatic int unsigned rnd_blk();
    return $urandom_range(0, (1 << BLK_W) - 1);
  endfunction

  function automatic int unsigned rnd_page();
    return $urandom_range(0, (1 << PAGE_W) - 1);
  endfunction

  // Send one item. Start stays high from one item to the next unless the
  // sender decides to idle, so it is never lowered and raised in one step.
  // The caller lowers it through wait_replies_drained before any pause.
  task automatic issue_request(input req_t r);
    @(negedge clk_i);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do begin
        @(negedge clk_i);
      end while ($urandom_range(0, 99) < idle_pct);
    end
    start <= 1'b1;
    req_r <= r;
    // Hold the item until an edge sees busy low; that edge takes it.
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    allocator_reply(r);
    req_count++;
  endtask

  // Drop start and wait for every owed reply to come back.
  task automatic wait_replies_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Reply side: the block drives each reply for one cycle, with no stall.
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [NUM_W-1:0] want,
                             input logic [NUM_W-1:0] got);
    if (got !== want) begin
      reply_mismatches++;
      if (reply_mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_replies
    res_t want;
    if (rst_ni && valid_o === 1'b1) begin
      if (pending_replies.size() == 0) begin
        reply_mismatches++;
        if (reply_mismatches <= MAX_REPORTS)
          $display("%0t: reply %h with none outstanding", $time, res_o);
      end else begin
        want = pending_replies.pop_front();
        check_field("status",        want.status,        res_o.status);
        check_field("is_bad",        want.is_bad,        res_o.is_bad);
        check_field("write_address", want.write_address, res_o.write_address);
        check_field("next_address",  want.next_address,  res_o.next_address);
        check_field("file_start",    want.file_start,    res_o.file_start);
        check_field("file_number",   want.file_number,   res_o.file_number);
        check_field("page_in_file",  want.page_in_file,  res_o.page_in_file);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every request code and the corner cases seen from reset.
  task automatic test_first_requests();
    // Refuse a page write while no file is open.
    issue_request(mk_req(REQ_PAGE_WRITTEN, rnd_blk(), rnd_page()));
    // Probe block queries at both map ends, just past it and at the field top.
    issue_request(mk_req(REQ_QUERY_BLOCK, 0, rnd_page()));
    issue_request(mk_req(REQ_QUERY_BLOCK, NBLK - 1, rnd_page()));
    issue_request(mk_req(REQ_QUERY_BLOCK, NBLK, rnd_page()));
    issue_request(mk_req(REQ_QUERY_BLOCK, (1 << BLK_W) - 1, rnd_page()));
    // Same for page queries; pages past the ring read as bad.
    issue_request(mk_req(REQ_QUERY_PAGE, rnd_blk(), 0));
    issue_request(mk_req(REQ_QUERY_PAGE, rnd_blk(), PAGE_SPACE - 1));
    issue_request(mk_req(REQ_QUERY_PAGE, rnd_blk(), PAGE_SPACE));
    issue_request(mk_req(REQ_QUERY_PAGE, rnd_blk(), (1 << PAGE_W) - 1));
    // Mark both map ends bad; out-of-range marks fail and leave the map alone.
    issue_request(mk_req(REQ_MARK_BAD, 0, rnd_page()));
    issue_request(mk_req(REQ_MARK_BAD, NBLK - 1, rnd_page()));
    issue_request(mk_req(REQ_MARK_BAD, NBLK, rnd_page()));
    issue_request(mk_req(REQ_MARK_GOOD, (1 << BLK_W) - 1, rnd_page()));
    issue_request(mk_req(REQ_QUERY_BLOCK, 0, rnd_page()));
    issue_request(mk_req(REQ_QUERY_PAGE, rnd_blk(), PAGE_SPACE - 1));
    issue_request(mk_req(REQ_UNUSED, rnd_blk(), rnd_page()));
    // First file skips the bad block 0; later files start one block on.
    issue_request(mk_req(REQ_NEW_FILE, rnd_blk(), rnd_page()));
    issue_request(mk_req(REQ_PAGE_WRITTEN, rnd_blk(), rnd_page()));
    issue_request(mk_req(REQ_NEW_FILE, rnd_blk(), rnd_page()));
    issue_request(mk_req(REQ_PAGE_WRITTEN, rnd_blk(), rnd_page()));
    issue_request(mk_req(REQ_MARK_GOOD, 0, rnd_page()));
    issue_request(mk_req(REQ_CLEAR_MAP, rnd_blk(), rnd_page()));
    issue_request(mk_req(REQ_QUERY_BLOCK, NBLK - 1, rnd_page()));
  endtask

  // Leave only two good blocks, walk the pointer across the ring end both
  // ways, then mark the last one bad so that the search runs out.
  task automatic test_ring_exhaustion();
    int unsigned b;
    int unsigned g0;
    int unsigned stride;
    int unsigned off;
    int unsigned blk;
    issue_request(mk_req(REQ_CLEAR_MAP, rnd_blk(), rnd_page()));
    // Park the file somewhere inside the map so that a lower good block exists.
    do begin
      issue_request(mk_req(REQ_NEW_FILE, rnd_blk(), rnd_page()));
      b = write_ptr / PPB;
    end while (b < 2 || b > NBLK - 3);
    g0     = $urandom_range(1, b - 1);
    // An odd stride visits every block once, in a scrambled order.
    stride = 2 * $urandom_range(0, NBLK / 2 - 1) + 1;
    off    = $urandom_range(0, NBLK - 1);
    for (int i = 0; i < NBLK; i++) begin
      blk = (i * stride + off) % NBLK;
      if (blk != g0 && blk != NBLK - 1)
        issue_request(mk_req(REQ_MARK_BAD, blk, rnd_page()));
    end
    // Skip forward to the last block, fill it, and wrap through page 0 to g0.
    issue_request(mk_req(REQ_PAGE_WRITTEN, rnd_blk(), rnd_page()));
    repeat (PPB) issue_request(mk_req(REQ_PAGE_WRITTEN, rnd_blk(), rnd_page()));
    issue_request(mk_req(REQ_NEW_FILE, rnd_blk(), rnd_page()));
    issue_request(mk_req(REQ_MARK_BAD, NBLK - 1, rnd_page()));
    issue_request(mk_req(REQ_NEW_FILE, rnd_blk(), rnd_page()));
    issue_request(mk_req(REQ_QUERY_PAGE, rnd_blk(), write_ptr));
    // With no good block left both searches give up, yet still take effect.
    issue_request(mk_req(REQ_MARK_BAD, g0, rnd_page()));
    issue_request(mk_req(REQ_NEW_FILE, rnd_blk(), rnd_page()));
    issue_request(mk_req(REQ_PAGE_WRITTEN, rnd_blk(), rnd_page()));
    issue_request(mk_req(REQ_QUERY_BLOCK, g0, rnd_page()));
    issue_request(mk_req(REQ_CLEAR_MAP, rnd_blk(), rnd_page()));
    issue_request(mk_req(REQ_PAGE_WRITTEN, rnd_blk(), rnd_page()));
  endtask

  // Mostly file-writing runs that drop bad blocks just ahead of the pointer,
  // mixed with map edits, queries, stray codes and the odd map clear.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned      first;
    int unsigned      len;
    int unsigned      roll;
    int unsigned      kind;
    logic [REQ_W-1:0] t;
    first = req_count;
    while (req_count - first < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        if ($urandom_range(0, 3) != 0)
          issue_request(mk_req(REQ_NEW_FILE, rnd_blk(), rnd_page()));
        // Now and then write past a whole block so the pointer crosses into the next.
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(PPB, PPB * 5 / 2)
                                          : $urandom_range(1, 30);
        repeat (len) begin
          roll = $urandom_range(0, 99);
          if (roll < 10)
            issue_request(mk_req(REQ_MARK_BAD, write_ptr / PPB + $urandom_range(0, 3),
                                 rnd_page()));
          else if (roll < 16)
            issue_request(mk_req(REQ_QUERY_PAGE, rnd_blk(),
                                 write_ptr + $urandom_range(0, 255)));
          else
            issue_request(mk_req(REQ_PAGE_WRITTEN, rnd_blk(), rnd_page()));
        end
      end else if (kind < 90) begin
        len = $urandom_range(1, 20);
        repeat (len) begin
          case ($urandom_range(0, 3))
            0:       t = REQ_MARK_BAD;
            1:       t = REQ_MARK_GOOD;
            2:       t = REQ_QUERY_BLOCK;
            default: t = REQ_QUERY_PAGE;
          endcase
          issue_request(mk_req(t,
            ($urandom_range(0, 7) == 0) ? rnd_blk() : $urandom_range(0, NBLK - 1),
            ($urandom_range(0, 1) == 0) ? rnd_page() : $urandom_range(0, PAGE_SPACE - 1)));
        end
      end else if (kind < 97) begin
        issue_request(mk_req(REQ_W'($urandom_range(0, (1 << REQ_W) - 1)), rnd_blk(),
                             rnd_page()));
      end else begin
        issue_request(mk_req(REQ_CLEAR_MAP, rnd_blk(), rnd_page()));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    // Start the shadow from the reset state of the block.
    foreach (shadow_map[i]) shadow_map[i] = 1'b0;
    file_is_open    = 1'b0;
    file_num        = '0;
    file_page_cnt   = '0;
    file_first_page = 0;
    write_ptr       = 0;

    // Hold reset low, then release it away from the rising edge.
    // Busy covers the map sweep that follows, so the first item just waits.
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    idle_pct = 15;
    test_first_requests();
    test_ring_exhaustion();
    test_random_traffic(50);
    // Sender idles most of the time.
    idle_pct = 88;
    test_random_traffic(50);
    // Back-to-back items.
    idle_pct = 0;
    test_random_traffic(50);

    // Let any stray late reply show up after the last owed one.
    wait_replies_drained();
    repeat (16) @(posedge clk_i);
    if (reply_mismatches == 0 && pending_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Stop a hung run; this is many times the slowest legal run of the sequence.
  initial begin
    #500_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> nand_bad_block_map_allocator_top.f
rtl/bbm_pkg.sv
rtl/bbm_ram.sv
rtl/bbm_front.sv
rtl/bbm_queue.sv
rtl/bbm_back.sv
rtl/nand_bad_block_map_allocator_top.sv
verif/nand_bad_block_map_allocator_top_test.sv
